### design/efjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efjd_pkg: shared types and helpers for the escaped frame joystick decoder
// Frame geometry, escape codes, register indexes, CRC and speed scaling.
// ----------------------------------------------------------------------------
package efjd_pkg;

	localparam int MAX_FRAME_BYTES = 257;
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
	localparam int NUM_CH = 4;
	localparam int CH_W = 2;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CMP_W-1:0] cmp_t;

	localparam pos_t POS_ADDR  = pos_t'(0);
	localparam pos_t POS_LEN   = pos_t'(1);
	localparam pos_t POS_FIX0  = pos_t'(2);
	localparam pos_t POS_FIX1  = pos_t'(3);
	localparam pos_t POS_FIX2  = pos_t'(4);
	localparam pos_t POS_KNOB0 = pos_t'(5);
	localparam pos_t POS_KNOB1 = pos_t'(6);
	localparam pos_t POS_KNOB2 = pos_t'(7);
	localparam pos_t POS_KNOB3 = pos_t'(9);
	localparam pos_t POS_MIN   = pos_t'(5);
	localparam pos_t POS_MAX   = pos_t'(MAX_FRAME_BYTES);

	localparam logic [7:0] ESC_CHAR  = 8'h1B;
	localparam logic [7:0] ESC_ZERO  = 8'h00;
	localparam logic [7:0] ESC_STX   = 8'hE7;
	localparam logic [7:0] STX_CHAR  = 8'h02;
	localparam logic [7:0] NUL_CHAR  = 8'h00;
	localparam logic [7:0] FIX_BYTE0 = 8'h11;
	localparam logic [7:0] FIX_BYTE1 = 8'h01;
	localparam logic [7:0] FIX_BYTE2 = 8'h03;

	localparam logic [7:0] KNOB_REV_CENTER = 8'd127;
	localparam logic [7:0] KNOB_FWD_CENTER = 8'd128;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// dist * 100 / 127 as a multiply by round-up reciprocal, exact for dist <= 128
	localparam logic [20:0] SPEED_MUL = 21'd1651301;
	localparam int SPEED_SHIFT = 21;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_STATION = 2'd0;
	localparam cfg_idx_t REG_DZ_LOW  = 2'd1;
	localparam cfg_idx_t REG_DZ_HIGH = 2'd2;

	localparam logic [7:0] RST_STATION = 8'd2;
	localparam logic [7:0] RST_DZ_LOW  = 8'd120;
	localparam logic [7:0] RST_DZ_HIGH = 8'd135;

	typedef struct packed {
		logic                   ok;
		logic [NUM_CH-1:0][7:0] knob;
	} frame_rec_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] speed_pct(input logic [7:0] span);
		logic [28:0] prod;
		prod = {21'd0, span} * {8'd0, SPEED_MUL};
		return prod[SPEED_SHIFT +: 7];
	endfunction

endpackage

### design/efjd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efjd_frame: unescape and frame check
// Removes escapes byte by byte, tracks header, length and running CRC, and
// presents the verdict and knob bytes on the beat that ends a frame.
// ----------------------------------------------------------------------------
module efjd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_end,
	input  logic [7:0]           station_address,
	output logic                 done,
	output efjd_pkg::frame_rec_t rec
);

	logic                                  esc_q, esc_d;
	efjd_pkg::pos_t                        pos_q, pos_d;
	logic [7:0]                            len_q, len_d;
	logic                                  hm_q, hm_d;
	logic [15:0]                           crc_q, crc_d;
	logic [15:0]                           crx_q, crx_d;
	logic [efjd_pkg::NUM_CH-1:0][7:0]      knob_q, knob_d;
	logic                                  take;
	logic [7:0]                            b;
	efjd_pkg::cmp_t                        pos_c, len_c;

	assign pos_c = efjd_pkg::cmp_t'(pos_q);
	assign len_c = efjd_pkg::cmp_t'(len_q);

	always_comb begin
		esc_d  = esc_q;
		take   = 1'b0;
		b      = rx_byte;
		pos_d  = pos_q;
		len_d  = len_q;
		hm_d   = hm_q;
		crc_d  = crc_q;
		crx_d  = crx_q;
		knob_d = knob_q;
		if (esc_q) begin
			esc_d = 1'b0;
			take  = 1'b1;
			if (rx_byte == efjd_pkg::ESC_ZERO) begin
				b = efjd_pkg::ESC_CHAR;
			end else if (rx_byte == efjd_pkg::ESC_STX) begin
				b = efjd_pkg::STX_CHAR;
			end else begin
				b = efjd_pkg::NUL_CHAR;
			end
		end else if (rx_byte == efjd_pkg::ESC_CHAR) begin
			if (frame_end) begin
				take = 1'b1;
			end else begin
				esc_d = 1'b1;
			end
		end else begin
			take = 1'b1;
		end
		if (take) begin
			if (pos_q >= efjd_pkg::POS_MAX) begin
				hm_d = 1'b0;
			end else begin
				case (pos_q)
					efjd_pkg::POS_ADDR: begin
						if (b != station_address) hm_d = 1'b0;
					end
					efjd_pkg::POS_LEN:   len_d = b;
					efjd_pkg::POS_FIX0: begin
						if (b != efjd_pkg::FIX_BYTE0) hm_d = 1'b0;
					end
					efjd_pkg::POS_FIX1: begin
						if (b != efjd_pkg::FIX_BYTE1) hm_d = 1'b0;
					end
					efjd_pkg::POS_FIX2: begin
						if (b != efjd_pkg::FIX_BYTE2) hm_d = 1'b0;
					end
					efjd_pkg::POS_KNOB0: knob_d[0] = b;
					efjd_pkg::POS_KNOB1: knob_d[1] = b;
					efjd_pkg::POS_KNOB2: knob_d[2] = b;
					efjd_pkg::POS_KNOB3: knob_d[3] = b;
					default: ;
				endcase
				if (pos_q < efjd_pkg::POS_FIX0 || pos_c < len_c) begin
					crc_d = efjd_pkg::crc_byte(crc_q, b);
				end
				if (pos_q >= efjd_pkg::POS_FIX0) begin
					if (pos_c == len_c) begin
						crx_d[7:0] = b;
					end else if (pos_c == len_c + efjd_pkg::cmp_t'(1)) begin
						crx_d[15:8] = b;
					end
				end
				pos_d = pos_q + efjd_pkg::pos_t'(1);
			end
		end
	end

	assign done      = beat & frame_end;
	assign rec.knob  = knob_d;
	assign rec.ok    = hm_d && (pos_d >= efjd_pkg::POS_MIN) &&
	                   (efjd_pkg::cmp_t'(pos_d) ==
	                    efjd_pkg::cmp_t'(len_d) + efjd_pkg::cmp_t'(2)) &&
	                   (crx_d == crc_d) && (crc_d != 16'h0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			pos_q  <= '0;
			len_q  <= '0;
			hm_q   <= 1'b1;
			crc_q  <= efjd_pkg::CRC_INIT;
			crx_q  <= '0;
			knob_q <= '0;
		end else if (beat) begin
			if (frame_end) begin
				esc_q  <= 1'b0;
				pos_q  <= '0;
				len_q  <= '0;
				hm_q   <= 1'b1;
				crc_q  <= efjd_pkg::CRC_INIT;
				crx_q  <= '0;
				knob_q <= '0;
			end else begin
				esc_q  <= esc_d;
				pos_q  <= pos_d;
				len_q  <= len_d;
				hm_q   <= hm_d;
				crc_q  <= crc_d;
				crx_q  <= crx_d;
				knob_q <= knob_d;
			end
		end
	end

endmodule

### design/escaped_frame_joystick_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_joystick_decoder_unit: joystick frame decoder top level
// Unescapes, checks and decodes frames into four channel results.
// ----------------------------------------------------------------------------
// One raw byte is taken per unstalled cycle; escape removal, header and
// length checks and the CRC update finish in the cycle the beat is taken. The
// beat that ends a frame parks its verdict in a one-deep frame register; from
// there the four channel results (or one reject result) are emitted one beat
// per unstalled cycle. in_stall rises only while that frame register is full
// and the result side cannot take it, so bytes keep flowing during result
// delivery. Config writes are always ready and take effect on the next cycle.
module escaped_frame_joystick_decoder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       frame_ok,
	output logic [efjd_pkg::CH_W-1:0]  channel,
	output logic                       direction,
	output logic                       moving,
	output logic [6:0]                 speed,
	output logic                       last_result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  efjd_pkg::cfg_idx_t         cfg_index,
	input  logic [7:0]                 cfg_data
);

	logic [7:0]                        station_q, dz_low_q, dz_high_q;
	logic                              in_beat, out_beat, out_last;
	logic                              done;
	efjd_pkg::frame_rec_t              rec, rec_s1;
	logic                              valid_s1_q;
	logic                              s1_move;
	logic [efjd_pkg::NUM_CH-1:0]       held_q;
	logic [efjd_pkg::NUM_CH-1:0]       dir_d, mv_d;
	logic [efjd_pkg::NUM_CH-1:0][6:0]  spd_d;
	logic [efjd_pkg::NUM_CH-1:0]       dir_q, mv_q;
	logic [efjd_pkg::NUM_CH-1:0][6:0]  spd_q;
	logic                              ok_q, out_valid_q;
	logic [efjd_pkg::CH_W-1:0]         cnt_q;
	logic [7:0]                        v, span;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= efjd_pkg::RST_STATION;
			dz_low_q  <= efjd_pkg::RST_DZ_LOW;
			dz_high_q <= efjd_pkg::RST_DZ_HIGH;
		end else if (cfg_valid) begin
			case (cfg_index)
				efjd_pkg::REG_STATION: station_q <= cfg_data;
				efjd_pkg::REG_DZ_LOW:  dz_low_q  <= cfg_data;
				efjd_pkg::REG_DZ_HIGH: dz_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_beat  = in_valid & ~in_stall;
	assign out_beat = out_valid_q & ~out_stall;
	assign out_last = ~ok_q | (cnt_q == efjd_pkg::CH_W'(efjd_pkg::NUM_CH - 1));
	assign s1_move  = valid_s1_q & (~out_valid_q | (out_beat & out_last));
	assign in_stall = valid_s1_q & ~s1_move;

	efjd_frame u_frame (
		.clk             (clk),
		.arst_n          (arst_n),
		.beat            (in_beat),
		.rx_byte         (rx_byte),
		.frame_end       (frame_end),
		.station_address (station_q),
		.done            (done),
		.rec             (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (done) begin
			valid_s1_q <= 1'b1;
		end else if (s1_move) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rec_s1 <= rec;
		end
	end

	// dead zone classification per channel, reverse test first
	always_comb begin
		dir_d = held_q;
		mv_d  = '0;
		spd_d = '0;
		v     = '0;
		span  = '0;
		for (int ch = 0; ch < efjd_pkg::NUM_CH; ch++) begin
			v    = rec_s1.knob[ch];
			span = '0;
			if (v < dz_low_q) begin
				dir_d[ch] = 1'b0;
				mv_d[ch]  = 1'b1;
				span = (v <= efjd_pkg::KNOB_REV_CENTER) ? (efjd_pkg::KNOB_REV_CENTER - v)
				                                        : (v - efjd_pkg::KNOB_REV_CENTER);
			end else if (v > dz_high_q) begin
				dir_d[ch] = 1'b1;
				mv_d[ch]  = 1'b1;
				span = (v >= efjd_pkg::KNOB_FWD_CENTER) ? (v - efjd_pkg::KNOB_FWD_CENTER)
				                                        : (efjd_pkg::KNOB_FWD_CENTER - v);
			end
			spd_d[ch] = efjd_pkg::speed_pct(span);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
			cnt_q       <= '0;
			if (rec_s1.ok) begin
				held_q <= dir_d;
			end
		end else if (out_beat) begin
			if (out_last) begin
				out_valid_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + efjd_pkg::CH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ok_q  <= rec_s1.ok;
			dir_q <= dir_d;
			mv_q  <= mv_d;
			spd_q <= spd_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_ok    = ok_q;
	assign channel     = ok_q ? cnt_q : '0;
	assign direction   = ok_q & dir_q[cnt_q];
	assign moving      = ok_q & mv_q[cnt_q];
	assign speed       = ok_q ? spd_q[cnt_q] : '0;
	assign last_result = out_last;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q && !s1_move |=> valid_s1_q)
		else $error("frame register dropped a waiting frame");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1_q && out_valid_q)
		else $error("input stalled without a waiting frame");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_ok |-> last_result && channel == '0)
		else $error("reject result not a single final beat");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !out_last && !s1_move |=> cnt_q == $past(cnt_q) + efjd_pkg::CH_W'(1))
		else $error("channel counter did not advance");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && out_last && !s1_move |=> !out_valid_q)
		else $error("result valid held past the final beat");

endmodule
